### rtl/core/hmc_pkg.sv
// Shared types and constants for the health mode controller.
// Holds the in/out word layouts, state and configuration structs and codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hmc_pkg;

    // Mode codes
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_REDUCED  = 2'd1;
    localparam logic [1:0] MODE_SAFE     = 2'd2;
    localparam logic [1:0] MODE_RECOVERY = 2'd3;

    // Event codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_HEALTH  = 2'd1;
    localparam logic [1:0] OP_FAILURE = 2'd2;
    localparam logic [1:0] OP_SUCCESS = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_HOLDOFF = 2'd0;
    localparam logic [1:0] CFG_DEGRADE = 2'd1;
    localparam logic [1:0] CFG_SAFE    = 2'd2;
    localparam logic [1:0] CFG_RESTORE = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] HOLDOFF_RESET = 16'd5000;
    localparam logic [7:0]  DEGRADE_RESET = 8'd80;
    localparam logic [7:0]  SAFE_RESET    = 8'd60;
    localparam logic [7:0]  RESTORE_RESET = 8'd85;

    // Hysteresis around the degrade level and failure run that forces recovery
    localparam logic [8:0] HYSTERESIS = 9'd5;
    localparam logic [7:0] FAIL_LIMIT = 8'd3;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;
    localparam logic [7:0]  FAIL_MAX  = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] health;
    } in_word_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] prior_mode;
        logic       mode_changed;
        logic [7:0] failure_count;
        logic       streaming_enabled;
        logic       high_quality_enabled;
        logic       telemetry_enabled;
        logic       monitoring_enabled;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  prior_mode;
        logic [15:0] holdoff_timer;
        logic [7:0]  fail_count;
    } hmc_state_t;

    typedef struct packed {
        logic [15:0] holdoff_ms;
        logic [7:0]  degrade_level;
        logic [7:0]  safe_level;
        logic [7:0]  restore_level;
    } hmc_cfg_t;

endpackage

`default_nettype wire

### rtl/core/health_mode_controller.sv
// Top level of the health mode controller: input register, step logic, result register.
// Depends on hmc_pkg and hmc_step.
`timescale 1ns / 1ps
`default_nettype none

// One event word in, one result word out. Each word is held in the input
// register and then moves into the result register, and a new word is taken
// every cycle as long as the result side keeps up; the mode, prior mode,
// hold-off timer and failure counter are updated in that one step, which sets
// the one-word-per-cycle rate. The configuration registers take effect on the
// next event and are meant to be written while no word is in flight.
module health_mode_controller
    import hmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    hmc_cfg_t   cfg_reg;
    hmc_state_t state_reg;
    hmc_state_t state_next;
    in_word_t   item_reg;
    logic       item_valid_reg;
    out_word_t  out_reg;
    out_word_t  out_next;
    logic       out_valid_reg;
    logic       advance;

    // Move the held word on when the result register is free or being drained
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.holdoff_ms    <= HOLDOFF_RESET;
            cfg_reg.degrade_level <= DEGRADE_RESET;
            cfg_reg.safe_level    <= SAFE_RESET;
            cfg_reg.restore_level <= RESTORE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLDOFF: cfg_reg.holdoff_ms    <= cfg_data;
                CFG_DEGRADE: cfg_reg.degrade_level <= cfg_data[7:0];
                CFG_SAFE:    cfg_reg.safe_level    <= cfg_data[7:0];
                CFG_RESTORE: cfg_reg.restore_level <= cfg_data[7:0];
                default:     cfg_reg.holdoff_ms    <= cfg_reg.holdoff_ms;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_word;
    end

    hmc_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (out_next)
    );

    // Controller state advances once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= MODE_NORMAL;
            state_reg.prior_mode    <= MODE_NORMAL;
            state_reg.holdoff_timer <= 16'd0;
            state_reg.fail_count    <= 8'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    // A reported change always names two different modes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.mode_changed |-> out_word.mode != out_word.prior_mode)
        else $error("mode change reported with equal prior mode");

    // The result word mirrors the controller state after its event
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_word.mode == state_reg.mode
                    && out_word.failure_count == state_reg.fail_count)
        else $error("result word out of step with controller state");

    // Any mode change restarts the hold-off timer
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && out_next.mode_changed |=> state_reg.holdoff_timer == 16'd0)
        else $error("hold-off timer not restarted on mode change");

    // Input is only held off while a word waits in the input register and the result register is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> item_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

### rtl/core/hmc_step.sv
// Next-state and result logic for one event of the health mode controller.
// Depends on hmc_pkg for the word, state and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module hmc_step
    import hmc_pkg::*;
(
    input  hmc_state_t state,
    input  hmc_cfg_t   cfg,
    input  in_word_t   item,
    output hmc_state_t state_next,
    output out_word_t  result
);

    logic [1:0] target;
    logic       holdoff_met;
    logic       health_change;
    logic [8:0] health_ext;
    logic [8:0] degrade_ext;
    logic [7:0] fail_inc;
    logic       changed;
    logic [1:0] mode_sel;
    logic [7:0] fail_next;
    logic [15:0] timer_next;

    assign health_ext  = {1'b0, item.health};
    assign degrade_ext = {1'b0, cfg.degrade_level};
    assign holdoff_met = (state.holdoff_timer >= cfg.holdoff_ms);
    assign fail_inc    = (state.fail_count == FAIL_MAX) ? FAIL_MAX : state.fail_count + 8'd1;

    // Pick the health-driven target mode
    always_comb
    begin
        target = state.mode;
        if (item.health < cfg.safe_level)
        begin
            target = MODE_SAFE;
        end
        else if (item.health < cfg.degrade_level)
        begin
            if (state.mode == MODE_NORMAL)
                target = MODE_REDUCED;
        end
        else if (item.health > cfg.restore_level)
        begin
            if (state.mode == MODE_REDUCED)
                target = MODE_NORMAL;
        end
    end

    // Gate the health change by hold-off and hysteresis
    always_comb
    begin
        health_change = holdoff_met && (target != state.mode);
        if (state.mode == MODE_NORMAL && target == MODE_REDUCED
            && !(health_ext + HYSTERESIS < degrade_ext))
            health_change = 1'b0;
        if (state.mode == MODE_REDUCED && target == MODE_NORMAL
            && !(health_ext > degrade_ext + HYSTERESIS))
            health_change = 1'b0;
    end

    // Apply the event
    always_comb
    begin
        changed    = 1'b0;
        mode_sel   = state.mode;
        fail_next  = state.fail_count;
        timer_next = state.holdoff_timer;
        case (item.opcode)
            OP_TICK:
            begin
                if (state.holdoff_timer != TIMER_MAX)
                    timer_next = state.holdoff_timer + 16'd1;
            end
            OP_HEALTH:
            begin
                changed  = health_change;
                mode_sel = target;
            end
            OP_FAILURE:
            begin
                fail_next = fail_inc;
                changed   = (fail_inc >= FAIL_LIMIT) && (state.mode != MODE_RECOVERY);
                mode_sel  = MODE_RECOVERY;
            end
            default:
            begin
                if (state.fail_count != 8'd0)
                    fail_next = state.fail_count - 8'd1;
            end
        endcase
    end

    // Commit the new state; a change restarts the hold-off timer
    always_comb
    begin
        state_next.fail_count = fail_next;
        if (changed)
        begin
            state_next.mode          = mode_sel;
            state_next.prior_mode    = state.mode;
            state_next.holdoff_timer = 16'd0;
        end
        else
        begin
            state_next.mode          = state.mode;
            state_next.prior_mode    = state.prior_mode;
            state_next.holdoff_timer = timer_next;
        end
    end

    // Build the result word from the state after the event
    always_comb
    begin
        result.mode                 = state_next.mode;
        result.prior_mode           = state_next.prior_mode;
        result.mode_changed         = changed;
        result.failure_count        = fail_next;
        result.streaming_enabled    = (state_next.mode != MODE_RECOVERY);
        result.high_quality_enabled = (state_next.mode == MODE_NORMAL);
        result.telemetry_enabled    = (state_next.mode != MODE_RECOVERY);
        result.monitoring_enabled   = (state_next.mode == MODE_NORMAL)
                                      || (state_next.mode == MODE_REDUCED);
    end

endmodule

`default_nettype wire
